>>> hw/rtl/sadc_pkg.sv
// package: shared constants, request codes and phase type for the serial adc frame controller
`default_nettype none

package sadc_pkg;

   // default geometry of the converter
   localparam int DEF_RESULT_BITS  = 10;
   localparam int DEF_ADDRESS_BITS = 4;
   localparam int DEF_FRAME_CLOCKS = 16;

   // park channel register
   localparam int CSR_DATA_W = 4;
   localparam int PARK_RESET = 13;

   // request codes on the mode field
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CONVERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESYNC  = 2'd2;

   // frame sequencer phases
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_RS_CS  = 3'd1,
      PH_RS_CLK = 3'd2,
      PH_C1_CS  = 3'd3,
      PH_C1_CLK = 3'd4,
      PH_C2_CS  = 3'd5,
      PH_C2_CLK = 3'd6
   } phase_type;

endpackage

`default_nettype wire

>>> hw/rtl/serial_adc_frame_controller_unit.sv
// top level: serial adc frame controller, one bit slot per transaction
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  req     | in        | req_tvalid/req_tready | mode, channel, dout_bit (one bit slot)
//  rsp     | out       | rsp_tvalid/rsp_tready | pin levels, busy, done, sample, sync flag
//  csr     | in        | csr_valid/csr_ready   | park channel
//
//  for every slot, the sequencer update and the result word are formed in
//  one pass of logic between the phase/shift registers and the rsp output register
//  a new req transaction is taken each cycle while rsp is free or being drained
//  reset puts the sequencer into resync at a chip-select slot with sync lost set
//  rsp stall holds the result register and stops req; csr writes are always taken
`default_nettype none

module serial_adc_frame_controller_unit #(
   parameter int RESULT_BITS  = sadc_pkg::DEF_RESULT_BITS,
   parameter int ADDRESS_BITS = sadc_pkg::DEF_ADDRESS_BITS,
   parameter int FRAME_CLOCKS = sadc_pkg::DEF_FRAME_CLOCKS,
   localparam int REQ_W = ((sadc_pkg::MODE_W + ADDRESS_BITS + 1 + 7) / 8) * 8,
   localparam int RSP_W = ((RESULT_BITS + 6 + 7) / 8) * 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // config write
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [sadc_pkg::CSR_DATA_W-1:0] csr_data,    // park_channel
   // bit slot request
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [REQ_W-1:0]                req_tdata,   // mode, channel, dout_bit
   // slot result
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [RSP_W-1:0]                rsp_tdata    // chip_select, address_bit,
                                                             // clock_pulse, busy_res,
                                                             // done_res, sample_value,
                                                             // out_of_sync
);

   import sadc_pkg::*;

   localparam int CNT_MAX = (FRAME_CLOCKS > RESULT_BITS) ? FRAME_CLOCKS : RESULT_BITS;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);

   // request fields
   logic [MODE_W-1:0]       req_mode;
   logic [ADDRESS_BITS-1:0] req_channel;
   logic                    req_dout;
   logic                    req_accept;

   assign req_mode    = req_tdata[MODE_W-1:0];
   assign req_channel = req_tdata[MODE_W +: ADDRESS_BITS];
   assign req_dout    = req_tdata[MODE_W + ADDRESS_BITS];

   // sequencer state
   phase_type               phase_ff, phase_in;
   logic [CNT_W-1:0]        bit_count_ff, bit_count_in;
   logic [ADDRESS_BITS-1:0] addr_ff, addr_in;
   logic [RESULT_BITS-1:0]  result_ff, result_in;
   logic                    short_ff, short_in;      // frame cut to one clock less
   logic                    first_done_ff, first_done_in;
   logic                    sync_lost_ff, sync_lost_in;
   logic [ADDRESS_BITS-1:0] park_ff, park_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]        rsp_data_ff, rsp_data_in;

   // park channel write, masked to the address width
   logic [CSR_DATA_W+ADDRESS_BITS-1:0] csr_ext;

   assign csr_ready = 1'b1;
   assign csr_ext   = {{ADDRESS_BITS{1'b0}}, csr_data};
   assign park_in   = (csr_valid && csr_ready) ? csr_ext[ADDRESS_BITS-1:0] : park_ff;

   // output stage frees up when empty or drained this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      phase_type              ph;
      logic [CNT_W-1:0]       cnt_nx;
      logic [CNT_W-1:0]       limit;
      logic                   cs, ab, clk, busy, done;
      logic [RESULT_BITS-1:0] val;

      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      addr_in       = addr_ff;
      result_in     = result_ff;
      short_in      = short_ff;
      first_done_in = first_done_ff;
      sync_lost_in  = sync_lost_ff;
      ph            = phase_ff;
      cnt_nx        = bit_count_ff + CNT_W'(1);
      limit         = CNT_W'(FRAME_CLOCKS);
      cs            = 1'b0;
      ab            = 1'b0;
      clk           = 1'b0;
      busy          = 1'b0;
      done          = 1'b0;
      val           = '0;

      // idle slot that takes a request is already the first chip-select slot
      if (phase_ff == PH_IDLE) begin
         if (req_mode == MODE_CONVERT) begin
            addr_in = req_channel;
            ph      = PH_C1_CS;
         end else if (req_mode == MODE_RESYNC && sync_lost_ff) begin
            first_done_in = 1'b0;
            ph            = PH_RS_CS;
         end
      end

      unique case (ph)
         PH_RS_CS, PH_C1_CS, PH_C2_CS: begin
            if (ph != PH_C1_CS) begin
               addr_in = park_ff;
            end
            if (ph == PH_RS_CS) begin
               short_in = 1'b0;
            end
            if (ph == PH_C2_CS) begin
               result_in = '0;
            end
            bit_count_in = '0;
            cs           = 1'b1;
            busy         = 1'b1;
            ab           = addr_in[ADDRESS_BITS-1];
            phase_in     = (ph == PH_RS_CS) ? PH_RS_CLK :
                           (ph == PH_C1_CS) ? PH_C1_CLK : PH_C2_CLK;
         end
         PH_RS_CLK, PH_C1_CLK, PH_C2_CLK: begin
            busy     = 1'b1;
            clk      = 1'b1;
            ab       = addr_ff[ADDRESS_BITS-1];
            phase_in = ph;
            // readback window
            if (bit_count_ff < CNT_W'(RESULT_BITS)) begin
               if (ph == PH_RS_CLK) begin
                  if (!req_dout && first_done_ff) begin
                     short_in = 1'b1;
                  end
               end else if (ph == PH_C1_CLK) begin
                  if (!req_dout) begin
                     sync_lost_in = 1'b1;
                  end
               end else begin
                  result_in = {result_ff[RESULT_BITS-2:0], req_dout};
               end
            end
            // address pin holds its last bit once all are sent
            if (bit_count_ff < CNT_W'(ADDRESS_BITS - 1)) begin
               addr_in = {addr_ff[ADDRESS_BITS-2:0], 1'b0};
            end
            bit_count_in = cnt_nx;
            if (ph == PH_RS_CLK) begin
               limit = short_in ? CNT_W'(FRAME_CLOCKS - 1) : CNT_W'(FRAME_CLOCKS);
               if (cnt_nx >= limit) begin
                  if (!short_in && first_done_ff) begin
                     sync_lost_in = 1'b0;
                     phase_in     = PH_IDLE;
                  end else begin
                     first_done_in = 1'b1;
                     phase_in      = PH_RS_CS;
                  end
               end
            end else if (cnt_nx >= CNT_W'(FRAME_CLOCKS)) begin
               if (ph == PH_C1_CLK) begin
                  phase_in = PH_C2_CS;
               end else begin
                  done     = 1'b1;
                  val      = result_in;
                  phase_in = PH_IDLE;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      rsp_data_in = RSP_W'({sync_lost_in, val, done, busy, clk, ab, cs});

      // nothing moves without a slot
      if (!req_accept) begin
         phase_in      = phase_ff;
         bit_count_in  = bit_count_ff;
         addr_in       = addr_ff;
         result_in     = result_ff;
         short_in      = short_ff;
         first_done_in = first_done_ff;
         sync_lost_in  = sync_lost_ff;
         rsp_data_in   = rsp_data_ff;
      end

      rsp_valid_in = req_accept ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_RS_CS;
         bit_count_ff  <= '0;
         addr_ff       <= ADDRESS_BITS'(PARK_RESET);
         result_ff     <= '0;
         short_ff      <= 1'b0;
         first_done_ff <= 1'b0;
         sync_lost_ff  <= 1'b1;
         park_ff       <= ADDRESS_BITS'(PARK_RESET);
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         addr_ff       <= addr_in;
         result_ff     <= result_in;
         short_ff      <= short_in;
         first_done_ff <= first_done_in;
         sync_lost_ff  <= sync_lost_in;
         park_ff       <= park_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result word needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   // sync flag clears only at the end of a resync clock slot
   a_sync_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(sync_lost_ff) |-> ($past(req_accept) && $past(phase_ff) == PH_RS_CLK))
      else $error("sync flag cleared outside resync");

   // sequencer only advances on a slot
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> ($stable(phase_ff) && $stable(bit_count_ff)))
      else $error("sequencer moved without a slot");

   // convert request from idle lands in the first clocked slot
   a_convert: assert property (@(posedge clock) disable iff (reset)
      (req_accept && phase_ff == PH_IDLE && req_mode == MODE_CONVERT)
      |=> (phase_ff == PH_C1_CLK))
      else $error("convert request not started");

   // slot counter never passes the frame length
   a_count: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= CNT_W'(FRAME_CLOCKS))
      else $error("slot counter overran frame");
`endif

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// testbench: slot-by-slot check of the serial adc frame controller against its own predictor
`timescale 1ns / 1ps

module tb_top;
   import sadc_pkg::*;

   localparam int RESULT_BITS  = DEF_RESULT_BITS;
   localparam int ADDRESS_BITS = DEF_ADDRESS_BITS;
   localparam int FRAME_CLOCKS = DEF_FRAME_CLOCKS;
   localparam int REQ_W        = 8;
   localparam int RSP_W        = 16;

   // mode value three: not a request, treated like none
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int RANDOM_SLOTS = 1030;
   localparam int PARK_EVERY   = 250;

   // one result word, laid out exactly as rsp_tdata (chip_select in bit 0)
   typedef struct packed {
      logic                   out_of_sync;
      logic [RESULT_BITS-1:0] sample_value;
      logic                   done_res;
      logic                   busy_res;
      logic                   clock_pulse;
      logic                   address_bit;
      logic                   chip_select;
   } slot_result_t;

   // one row of the directed table; csr rows carry the park value in chan
   typedef struct packed {
      bit                      csr_row;
      logic [MODE_W-1:0]       mode;
      logic [ADDRESS_BITS-1:0] chan;
      logic                    dout;
      logic [7:0]              reps;
      bit                      typed;
      logic [RSP_W-1:0]        word;
   } stim_row_t;

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_DATA_W-1:0] csr_data;     // park_channel
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata;    // mode, channel, dout_bit
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_W-1:0]      rsp_tdata;    // chip_select, address_bit, clock_pulse, busy_res,
                                        // done_res, sample_value, out_of_sync

   serial_adc_frame_controller_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // predicted sequencer state, mirrors the block slot by slot
   phase_type               seq_phase;
   logic [4:0]              slot_cnt;
   logic [ADDRESS_BITS-1:0] addr_sr;
   logic [RESULT_BITS-1:0]  sample_sr;
   logic [4:0]              frame_len;
   logic                    synced_once;
   logic                    lost_sync;
   logic [ADDRESS_BITS-1:0] park_ch;

   slot_result_t expected_slots[$];
   int           mismatch_count;
   bit           calm;          // no idling on either side while set
   bit           clean_frame;   // readback of the current frame kept all ones
   stim_row_t    directed_rows[20];

   // --------------------------------------------------------------------
   // slot predictor
   // --------------------------------------------------------------------
   function automatic slot_result_t predict_slot(input logic [MODE_W-1:0] m,
                                                 input logic [ADDRESS_BITS-1:0] ch,
                                                 input logic d);
      slot_result_t r;
      r = '0;
      // requests are only looked at while idle; the taking slot is already a cs slot
      if (seq_phase == PH_IDLE) begin
         if (m == MODE_CONVERT) begin
            addr_sr   = ch;
            seq_phase = PH_C1_CS;
         end else if (m == MODE_RESYNC && lost_sync) begin
            synced_once = 1'b0;
            seq_phase   = PH_RS_CS;
         end
      end
      case (seq_phase)
         PH_RS_CS, PH_C1_CS, PH_C2_CS: begin
            if (seq_phase != PH_C1_CS) addr_sr = park_ch;
            if (seq_phase == PH_RS_CS) frame_len = 5'(FRAME_CLOCKS);
            if (seq_phase == PH_C2_CS) sample_sr = '0;
            slot_cnt      = '0;
            r.chip_select = 1'b1;
            r.busy_res    = 1'b1;
            r.address_bit = addr_sr[ADDRESS_BITS-1];
            seq_phase     = phase_type'(seq_phase + 3'd1);
         end
         PH_RS_CLK, PH_C1_CLK, PH_C2_CLK: begin
            r.busy_res    = 1'b1;
            r.clock_pulse = 1'b1;
            r.address_bit = addr_sr[ADDRESS_BITS-1];
            if (slot_cnt < RESULT_BITS) begin
               if (seq_phase == PH_RS_CLK) begin
                  // a zero shortens the frame, but not in the first resync frame
                  if (!d && synced_once) frame_len = 5'(FRAME_CLOCKS - 1);
               end else if (seq_phase == PH_C1_CLK) begin
                  if (!d) lost_sync = 1'b1;
               end else begin
                  sample_sr = {sample_sr[RESULT_BITS-2:0], d};
               end
            end
            // address pin keeps the last bit once all address bits are out
            if (slot_cnt < ADDRESS_BITS - 1) addr_sr = addr_sr << 1;
            slot_cnt = slot_cnt + 5'd1;
            if (seq_phase == PH_RS_CLK) begin
               if (slot_cnt >= frame_len) begin
                  if (frame_len == FRAME_CLOCKS && synced_once) begin
                     lost_sync = 1'b0;
                     seq_phase = PH_IDLE;
                  end else begin
                     synced_once = 1'b1;
                     seq_phase   = PH_RS_CS;
                  end
               end
            end else if (slot_cnt >= FRAME_CLOCKS) begin
               if (seq_phase == PH_C1_CLK) begin
                  seq_phase = PH_C2_CS;
               end else begin
                  r.done_res     = 1'b1;
                  r.sample_value = sample_sr;
                  seq_phase      = PH_IDLE;
               end
            end
         end
         default: seq_phase = PH_IDLE;
      endcase
      r.out_of_sync = lost_sync;
      return r;
   endfunction

   // --------------------------------------------------------------------
   // clock
   // --------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // --------------------------------------------------------------------
   // req side: one transaction per bit slot
   // --------------------------------------------------------------------
   task automatic send_slot(input logic [MODE_W-1:0] m, input logic [ADDRESS_BITS-1:0] ch,
                            input logic d, input bit typed, input logic [RSP_W-1:0] word);
      slot_result_t r;
      // occasional burst of idle cycles before the slot
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tdata  <= {1'b0, d, ch, m};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // the predictor always advances; a typed row overrides what is expected
      r = predict_slot(m, ch, d);
      if (typed) r = slot_result_t'(word);
      expected_slots.push_back(r);
   endtask

   // park channel write, only with nothing in flight
   task automatic write_park(input logic [ADDRESS_BITS-1:0] v);
      req_tvalid <= 1'b0;
      while (expected_slots.size() != 0) @(posedge clock);
      csr_data  <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      park_ch = v;
   endtask

   initial begin
      logic [MODE_W-1:0]       m;
      logic [ADDRESS_BITS-1:0] ch;
      logic                    d;
      int                      pick;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      calm        = 1'b0;
      clean_frame = 1'b1;

      // predictor reset: resync at a cs slot, sync lost
      park_ch     = ADDRESS_BITS'(PARK_RESET);
      seq_phase   = PH_RS_CS;
      slot_cnt    = '0;
      addr_sr     = ADDRESS_BITS'(PARK_RESET);
      sample_sr   = '0;
      frame_len   = 5'(FRAME_CLOCKS);
      synced_once = 1'b0;
      lost_sync   = 1'b1;

      // csr_row, mode, chan, dout, reps, typed, word
      directed_rows = '{
         // first slot after reset: resync cs with park 13 and the flag set
         '{1'b0, MODE_NONE,    4'd0,  1'b1, 8'd1,  1'b1, 16'h800B},
         // first resync frame ignores zeros
         '{1'b0, MODE_NONE,    4'd0,  1'b0, 8'd16, 1'b0, 16'h0000},
         '{1'b0, MODE_NONE,    4'd0,  1'b1, 8'd1,  1'b0, 16'h0000},
         // a zero in a later frame shortens it
         '{1'b0, MODE_NONE,    4'd0,  1'b1, 8'd3,  1'b0, 16'h0000},
         '{1'b0, MODE_NONE,    4'd0,  1'b0, 8'd1,  1'b0, 16'h0000},
         '{1'b0, MODE_NONE,    4'd0,  1'b1, 8'd11, 1'b0, 16'h0000},
         // clean full frame ends resync
         '{1'b0, MODE_NONE,    4'd0,  1'b1, 8'd17, 1'b0, 16'h0000},
         // idle slots, mode three and resync while in sync all stay idle
         '{1'b0, MODE_NONE,    4'd0,  1'b0, 8'd1,  1'b1, 16'h0000},
         '{1'b0, MODE_UNUSED,  4'd15, 1'b1, 8'd1,  1'b1, 16'h0000},
         '{1'b0, MODE_RESYNC,  4'd15, 1'b1, 8'd1,  1'b1, 16'h0000},
         '{1'b1, MODE_NONE,    4'd15, 1'b0, 8'd0,  1'b0, 16'h0000},
         // convert channel 15, full-scale sample on the done slot
         '{1'b0, MODE_CONVERT, 4'd15, 1'b1, 8'd33, 1'b0, 16'h0000},
         '{1'b0, MODE_NONE,    4'd0,  1'b1, 8'd1,  1'b1, 16'h7FFE},
         '{1'b1, MODE_NONE,    4'd0,  1'b0, 8'd0,  1'b0, 16'h0000},
         // bad readback loses sync, then a convert while out of sync
         '{1'b0, MODE_CONVERT, 4'd0,  1'b0, 8'd34, 1'b0, 16'h0000},
         '{1'b0, MODE_CONVERT, 4'd9,  1'b1, 8'd34, 1'b0, 16'h0000},
         '{1'b1, MODE_NONE,    4'd6,  1'b0, 8'd0,  1'b0, 16'h0000},
         // resync from idle with the flag set
         '{1'b0, MODE_RESYNC,  4'd0,  1'b1, 8'd17, 1'b0, 16'h0000},
         '{1'b0, MODE_NONE,    4'd0,  1'b1, 8'd17, 1'b0, 16'h0000},
         '{1'b0, MODE_CONVERT, 4'd10, 1'b1, 8'd34, 1'b0, 16'h0000}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].csr_row) begin
            write_park(directed_rows[i].chan);
         end else begin
            repeat (directed_rows[i].reps)
               send_slot(directed_rows[i].mode, directed_rows[i].chan, directed_rows[i].dout,
                         directed_rows[i].typed, directed_rows[i].word);
         end
      end

      // random part: mostly well-formed conversions and resyncs, noise in between
      for (int k = 0; k < RANDOM_SLOTS; k++) begin
         calm = (k >= RANDOM_SLOTS - 150) || ((k / 100) % 5 == 4);
         if (k % PARK_EVERY == PARK_EVERY / 2) begin
            case (k / PARK_EVERY)
               0:       write_park(4'd15);
               1:       write_park(4'd0);
               default: write_park(ADDRESS_BITS'($urandom_range(0, 15)));
            endcase
         end
         ch = ADDRESS_BITS'($urandom_range(0, 15));
         m  = MODE_W'($urandom_range(0, 3));
         if (seq_phase == PH_IDLE) begin
            pick = $urandom_range(0, 19);
            if (pick < 12)      m = MODE_CONVERT;
            else if (pick < 15) m = MODE_RESYNC;
            else if (pick < 17) m = MODE_NONE;
            else                m = MODE_UNUSED;
            clean_frame = ($urandom_range(0, 9) < 8);
         end else if (seq_phase == PH_RS_CS || seq_phase == PH_C1_CS) begin
            clean_frame = ($urandom_range(0, 9) < 8);
         end
         // clean frames keep the checked readback bits high
         if ((seq_phase == PH_RS_CLK || seq_phase == PH_C1_CLK) && clean_frame &&
             slot_cnt < RESULT_BITS)
            d = 1'b1;
         else
            d = 1'($urandom_range(0, 1));
         send_slot(m, ch, d, 1'b0, '0);
      end

      // drain, then a short tail for anything unexpected
      req_tvalid <= 1'b0;
      while (expected_slots.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_slots.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // --------------------------------------------------------------------
   // rsp side: random stall bursts, none while calm
   // --------------------------------------------------------------------
   initial begin
      rsp_tready <= 1'b1;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // --------------------------------------------------------------------
   // result checker
   // --------------------------------------------------------------------
   task automatic check_field(input string name, input logic [RSP_W-1:0] want,
                              input logic [RSP_W-1:0] got);
      if (got !== want) begin
         if (mismatch_count < 10)
            $display("mismatch on %s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   initial mismatch_count = 0;

   always @(posedge clock) begin
      slot_result_t got;
      slot_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = slot_result_t'(rsp_tdata);
         if (expected_slots.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected rsp transaction: %0h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_slots.pop_front();
            check_field("chip_select", RSP_W'(want.chip_select), RSP_W'(got.chip_select));
            check_field("address_bit", RSP_W'(want.address_bit), RSP_W'(got.address_bit));
            check_field("clock_pulse", RSP_W'(want.clock_pulse), RSP_W'(got.clock_pulse));
            check_field("busy_res", RSP_W'(want.busy_res), RSP_W'(got.busy_res));
            check_field("done_res", RSP_W'(want.done_res), RSP_W'(got.done_res));
            check_field("sample_value", RSP_W'(want.sample_value),
                        RSP_W'(got.sample_value));
            check_field("out_of_sync", RSP_W'(want.out_of_sync), RSP_W'(got.out_of_sync));
         end
      end
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/sadc_pkg.sv
hw/rtl/serial_adc_frame_controller_unit.sv
verif/tb_top.sv
